@@ design/dfc_pkg.sv @@
// Package: constants, types, rounding and saturation helpers, tanh table.
`default_nettype none
package dfc_pkg;
    localparam int LINE_DEPTH = 4096;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int TBL_SIZE   = 256;
    localparam int TBL_LOG2   = $clog2(TBL_SIZE);

    localparam logic signed [63:0] SAMPLE_MAX = 64'sd16777215;
    localparam logic signed [63:0] SAMPLE_MIN = -64'sd16777216;
    localparam logic signed [25:0] DC_COEF    = 26'sd65208;
    localparam logic signed [15:0] GAIN_LIMIT = 16'sd32440;
    localparam logic [15:0]        DAMP_ONE   = 16'd32768;
    localparam logic [27:0]        DELAY_MIN  = 28'd131072;
    localparam logic [27:0]        DELAY_MAX  = 28'(((LINE_DEPTH - 1) << 16) | 16'hFFFF);

    typedef enum logic [1:0] {
        REG_DELAY   = 2'd0,
        REG_GAIN    = 2'd1,
        REG_DAMPING = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    typedef logic [23:0] t_tanh_tbl [0:TBL_SIZE];

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    function automatic logic signed [24:0] sat25(input logic signed [63:0] x);
        logic signed [24:0] r;
        if (x > SAMPLE_MAX) begin
            r = 25'(SAMPLE_MAX);
        end else if (x < SAMPLE_MIN) begin
            r = 25'(SAMPLE_MIN);
        end else begin
            r = 25'(x);
        end
        return r;
    endfunction

    // shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(2k/SIZE) in Q0.23, from a Q28 series of e^(k/(4*SIZE)) squared four times
    function automatic t_tanh_tbl build_tanh();
        t_tanh_tbl tbl;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        for (int k = 0; k <= TBL_SIZE; k++) begin
            t    = 64'(k) << (26 - TBL_LOG2);
            term = 64'd1 << 28;
            e    = 64'd1 << 28;
            for (int n = 1; n <= 10; n++) begin
                term = udiv64((term * t) >> 28, 64'(n));
                e    = e + term;
            end
            for (int n = 0; n < 4; n++) begin
                e = (e * e) >> 28;
            end
            num    = (e - (64'd1 << 28)) << 23;
            den    = e + (64'd1 << 28);
            tbl[k] = 24'(udiv64(num + (den >> 1), den));
        end
        return tbl;
    endfunction

    localparam t_tanh_tbl TANH_TBL = build_tanh();
endpackage
`default_nettype wire

@@ design/damped_feedback_comb_filter_unit.sv @@
// Damped feedback comb filter: delay-line RAM and sequenced Q1.23 datapath.
//
// channel | dir | handshake                | payload
// in      | in  | i_in_valid / o_in_ready  | i_in_sample[23:0]
// out     | out | o_out_valid / i_out_ready| o_out_sample[24:0]
// cfg     | in  | i_cfg_valid / o_cfg_ready| i_cfg_index[1:0], i_cfg_data[27:0]
//
// A sample is accepted in ST_IDLE and runs from ST_RDB to ST_OD2; a new sample
// is taken only once the sequencer is back in ST_IDLE.
// The sequencer steps one shared 26x26 multiplier through every product.
// After reset the delay line is zeroed, all LINE_DEPTH (4096) entries; no request
// is taken on the in channel then. Config is always ready.
// A result waiting on out stalls the final step of the next sample.
`default_nettype none
module damped_feedback_comb_filter_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [23:0]  i_in_sample,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [24:0]       o_out_sample,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [27:0]         i_cfg_data
);
    import dfc_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RDB, ST_IP1, ST_IP2, ST_LP1, ST_LP2, ST_LP3,
        ST_DC1, ST_DC2, ST_FB1, ST_FB2, ST_TH1, ST_TH2, ST_OD1, ST_OD2
    } t_state;

    t_state                    r_state;
    logic [LINE_AW-1:0]        r_clr;
    logic [LINE_AW-1:0]        r_wp;
    logic [LINE_AW-1:0]        r_ib;
    logic [27:0]               r_delay;
    logic [15:0]               r_gain;
    logic [15:0]               r_damp;
    logic signed [23:0]        r_x;
    logic signed [24:0]        r_a;
    logic signed [24:0]        r_ip;
    logic signed [24:0]        r_lp;
    logic signed [24:0]        r_ldc_x;
    logic signed [24:0]        r_ldc_y;
    logic signed [24:0]        r_odc_x;
    logic signed [24:0]        r_odc_y;
    logic signed [24:0]        r_fb;
    logic signed [24:0]        r_th;
    logic [23:0]               r_lo;
    logic                      r_big;
    logic                      r_neg;
    logic signed [51:0]        r_prod;
    logic signed [51:0]        r_acc;
    logic                      r_out_valid;
    logic signed [24:0]        r_out;

    logic [27:0]               d_cl;
    logic [LINE_AW-1:0]        dint;
    logic [15:0]               dfrac;
    logic [LINE_AW-1:0]        ia;
    logic signed [15:0]        gain;
    logic [15:0]               damp;
    logic signed [25:0]        ma;
    logic signed [25:0]        mb;
    logic [24:0]               rdata;
    logic                      ram_we;
    logic [LINE_AW-1:0]        ram_waddr;
    logic [24:0]               ram_wdata;
    logic [LINE_AW-1:0]        ram_raddr;
    logic [24:0]               mag;
    logic [TBL_LOG2:0]         tidx;
    logic [TBL_LOG2:0]         tidx_hi;
    logic [23:0]               tfrac;
    logic [23:0]               tlo;
    logic [23:0]               thi;
    logic [23:0]               tdiff;
    logic signed [24:0]        loop_v;
    logic signed [24:0]        cur;
    logic [24:0]               th_mag;
    logic                      finish;

    always_comb begin
        if (r_delay < DELAY_MIN) begin
            d_cl = DELAY_MIN;
        end else if (r_delay > DELAY_MAX) begin
            d_cl = DELAY_MAX;
        end else begin
            d_cl = r_delay;
        end
        dint  = d_cl[16 +: LINE_AW];
        dfrac = d_cl[15:0];
        ia    = r_wp - dint;

        if ($signed(r_gain) > GAIN_LIMIT) begin
            gain = GAIN_LIMIT;
        end else if ($signed(r_gain) < -GAIN_LIMIT) begin
            gain = -GAIN_LIMIT;
        end else begin
            gain = $signed(r_gain);
        end
        damp = (r_damp > DAMP_ONE) ? DAMP_ONE : r_damp;
    end

    // tanh lookup on |fb|
    always_comb begin
        mag     = 25'(r_fb[24] ? -26'(r_fb) : 26'(r_fb));
        tidx    = mag[24 -: (TBL_LOG2 + 1)];
        tfrac   = {mag[23-TBL_LOG2:0], TBL_LOG2'(0)};
        tidx_hi = {1'b0, tidx[TBL_LOG2-1:0]} + (TBL_LOG2 + 1)'(1);
        tlo     = TANH_TBL[{1'b0, tidx[TBL_LOG2-1:0]}];
        thi     = TANH_TBL[tidx_hi];
        tdiff   = (thi >= tlo) ? thi - tlo : 24'd0;
    end

    assign loop_v = sat25(64'(r_x) + 64'(r_th));
    assign cur    = (gain == 16'sd0) ? 25'sd0 : r_th;
    assign th_mag = r_big ? 25'(TANH_TBL[TBL_SIZE])
                          : 25'(r_lo) + 25'(rnd_shift(64'(r_prod), 24));
    assign finish = (r_state == ST_OD2) && (!r_out_valid || i_out_ready);

    // shared multiplier operand select
    always_comb begin
        ma = 26'sd0;
        mb = 26'sd0;
        unique case (r_state)
            ST_IP1: begin
                ma = 26'($signed(rdata)) - 26'(r_a);
                mb = 26'($signed({1'b0, dfrac}));
            end
            ST_LP1: begin
                ma = 26'(r_ip);
                mb = 26'($signed({1'b0, DAMP_ONE - damp}));
            end
            ST_LP2: begin
                ma = 26'(r_lp);
                mb = 26'($signed({1'b0, damp}));
            end
            ST_DC1: begin
                ma = 26'(r_ldc_y);
                mb = DC_COEF;
            end
            ST_FB1: begin
                ma = 26'(r_lp - r_lp) + 26'(r_ldc_y);
                mb = 26'(gain);
            end
            ST_TH1: begin
                ma = 26'($signed({1'b0, tdiff}));
                mb = 26'($signed({1'b0, tfrac}));
            end
            ST_OD1, ST_OD2: begin
                ma = 26'(r_odc_y);
                mb = DC_COEF;
            end
            default: begin
                ma = 26'sd0;
                mb = 26'sd0;
            end
        endcase
    end

    always_comb begin
        ram_we    = (r_state == ST_CLEAR) || (r_state == ST_OD1);
        ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_wp;
        ram_wdata = (r_state == ST_CLEAR) ? 25'd0 : loop_v;
        ram_raddr = (r_state == ST_RDB) ? r_ib : ia;
    end

    dfc_ram #(
        .WIDTH(25),
        .DEPTH(LINE_DEPTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_delay     <= DELAY_MIN;
            r_gain      <= '0;
            r_damp      <= '0;
            r_lp        <= '0;
            r_ldc_x     <= '0;
            r_ldc_y     <= '0;
            r_odc_x     <= '0;
            r_odc_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_DELAY:   r_delay <= i_cfg_data;
                    REG_GAIN:    r_gain  <= i_cfg_data[15:0];
                    REG_DAMPING: r_damp  <= i_cfg_data[15:0];
                    REG_NONE:    ;
                endcase
            end
            if (o_out_valid && i_out_ready && !finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + LINE_AW'(1);
                    if (r_clr == LINE_AW'(LINE_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_in_sample;
                        r_ib    <= ia + LINE_AW'(1);
                        r_state <= ST_RDB;
                    end
                end
                ST_RDB: begin
                    r_a     <= $signed(rdata);
                    r_state <= ST_IP1;
                end
                ST_IP1: r_state <= ST_IP2;
                ST_IP2: begin
                    r_ip    <= sat25(64'(r_a) + rnd_shift(64'(r_prod), 16));
                    r_state <= ST_LP1;
                end
                ST_LP1: r_state <= ST_LP2;
                ST_LP2: begin
                    r_acc   <= r_prod;
                    r_state <= ST_LP3;
                end
                ST_LP3: begin
                    r_lp    <= sat25(rnd_shift(64'(r_acc) + 64'(r_prod), 15));
                    r_state <= ST_DC1;
                end
                ST_DC1: r_state <= ST_DC2;
                ST_DC2: begin
                    r_ldc_x <= r_lp;
                    r_ldc_y <= sat25(64'(r_lp) - 64'(r_ldc_x)
                                     + rnd_shift(64'(r_prod), 16));
                    r_state <= ST_FB1;
                end
                ST_FB1: r_state <= ST_FB2;
                ST_FB2: begin
                    r_fb    <= sat25(rnd_shift(64'(r_prod), 15));
                    r_state <= ST_TH1;
                end
                ST_TH1: begin
                    r_lo    <= tlo;
                    r_big   <= tidx[TBL_LOG2];
                    r_neg   <= r_fb[24];
                    r_state <= ST_TH2;
                end
                ST_TH2: begin
                    r_th    <= r_neg ? -th_mag : th_mag;
                    r_state <= ST_OD1;
                end
                ST_OD1: r_state <= ST_OD2;
                ST_OD2: begin
                    if (finish) begin
                        r_odc_x     <= cur;
                        r_odc_y     <= sat25(64'(cur) - 64'(r_odc_x)
                                             + rnd_shift(64'(r_prod), 16));
                        r_out       <= sat25(64'(cur) - 64'(r_odc_x)
                                             + rnd_shift(64'(r_prod), 16));
                        r_out_valid <= 1'b1;
                        r_wp        <= r_wp + LINE_AW'(1);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out;

`ifndef NO_ASSERTIONS
    a_no_in_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("input ready during clear pass");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while busy");
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_wp) |-> $past(finish))
        else $error("write pointer moved without a result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_sample)))
        else $error("pending result lost");
`endif
endmodule
`default_nettype wire

@@ design/dfc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dfc_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
